// ===== rtl/lmpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lmpd_pkg: shared types and constants of the 3x3 peak detector
// field widths, configuration register codes, queue sizing and the
// decision record passed from the front end to the report stage
// ----------------------------------------------------------------------------
package lmpd_pkg;

	localparam int DEF_MAX_WIDTH   = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int ROW_W     = 16;
	localparam int COL_W     = 11;
	localparam int NUM_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [NUM_W-1:0] TALLY_MAX = '1;

	localparam logic [COL_W-1:0] RST_FRAME_WIDTH   = COL_W'(1024);
	localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT  = ROW_W'(1024);
	localparam logic [ROW_W-1:0] RST_TARGET_ROW    = ROW_W'(1);
	localparam logic [COL_W-1:0] RST_TARGET_COLUMN = COL_W'(1);

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFREE_W     = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_TARGET_ROW    = 2'd2,
		CFG_TARGET_COLUMN = 2'd3
	} cfg_index_t;

	typedef enum logic {
		KIND_PEAK    = 1'b0,
		KIND_VERDICT = 1'b1
	} report_kind_t;

	// one queue entry: at most one peak plus an optional end-of-frame verdict
	typedef struct packed {
		logic             peak_v;
		logic [ROW_W-1:0] peak_row;
		logic [COL_W-1:0] peak_column;
		logic             verdict;
	} decision_t;

endpackage

// ===== rtl/lmpd_sample_if.sv =====
// ----------------------------------------------------------------------------
// lmpd_sample_if: input sample channel
// valid/ready handshake carrying one signed frame sample
// ----------------------------------------------------------------------------
interface lmpd_sample_if import lmpd_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);

endinterface

// ===== rtl/lmpd_report_if.sv =====
// ----------------------------------------------------------------------------
// lmpd_report_if: result channel
// valid/ready handshake carrying one peak report or frame verdict
// ----------------------------------------------------------------------------
interface lmpd_report_if import lmpd_pkg::*; ();

	logic             valid;
	logic             ready;
	logic             report_kind;
	logic [ROW_W-1:0] peak_row;
	logic [COL_W-1:0] peak_column;
	logic [NUM_W-1:0] peak_number;
	logic             target_hit;
	logic             last;

	modport source (
		output valid, output report_kind, output peak_row, output peak_column,
		output peak_number, output target_hit, output last, input ready
	);
	modport sink (
		input valid, input report_kind, input peak_row, input peak_column,
		input peak_number, input target_hit, input last, output ready
	);

endinterface

// ===== rtl/local_maximum_3x3_peak_detector.sv =====
// a sample's result passes s1, s2, the decision queue and the result
// register; when a frame's last sample also yields a peak, the verdict follows it
// throughput: one sample per cycle while the queue has room; an item with a peak
// and a verdict yields two results, absorbed by the 8-entry decision queue
// reset: position, window, peak count and hit mark clear at once, registers
// take their defaults; line stores are not cleared
// ----------------------------------------------------------------------------
// local_maximum_3x3_peak_detector: top level
// reports every sample strictly above its in-frame 3x3 neighbors with its
// 1-based position and ordinal, then a per-frame verdict on the target spot
// ----------------------------------------------------------------------------
module local_maximum_3x3_peak_detector import lmpd_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	lmpd_sample_if.sink          sample_ch,
	lmpd_report_if.source        report_ch
);

	// configuration registers
	logic [COL_W-1:0] frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic [ROW_W-1:0] target_row_q;
	logic [COL_W-1:0] target_column_q;

	// front to queue to back
	logic               push_v;
	decision_t          push_data;
	logic               pop;
	logic               head_v;
	decision_t          head;
	logic [QFREE_W-1:0] queue_free;

	// register writes, to be made only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= RST_FRAME_WIDTH;
			frame_height_q  <= RST_FRAME_HEIGHT;
			target_row_q    <= RST_TARGET_ROW;
			target_column_q <= RST_TARGET_COLUMN;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH:   frame_width_q   <= cfg_wdata[COL_W-1:0];
				CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_wdata[ROW_W-1:0];
				CFG_TARGET_ROW:    target_row_q    <= cfg_wdata[ROW_W-1:0];
				CFG_TARGET_COLUMN: target_column_q <= cfg_wdata[COL_W-1:0];
				default:           frame_width_q   <= frame_width_q;
			endcase
		end
	end

	// front: intake, line stores, window, decision per sample
	lmpd_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_ch    (sample_ch),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.queue_free   (queue_free),
		.push_v       (push_v),
		.push_data    (push_data)
	);

	// decision queue lets intake and result side stall apart
	lmpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_v     (push_v),
		.push_data  (push_data),
		.pop        (pop),
		.head_v     (head_v),
		.head       (head),
		.queue_free (queue_free)
	);

	// back: numbering, target watch, result register
	lmpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_v        (head_v),
		.head          (head),
		.target_row    (target_row_q),
		.target_column (target_column_q),
		.pop           (pop),
		.report_ch     (report_ch)
	);

endmodule

// ===== rtl/lmpd_front.sv =====
// ----------------------------------------------------------------------------
// lmpd_front: sample intake, line stores, 3x3 window and peak classification
// s1 updates the window from the line store reads, s2 decides the peaks
// ----------------------------------------------------------------------------
module lmpd_front import lmpd_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	lmpd_sample_if.sink        sample_ch,
	input  logic [COL_W-1:0]   frame_width,
	input  logic [ROW_W-1:0]   frame_height,
	input  logic [QFREE_W-1:0] queue_free,
	output logic               push_v,
	output decision_t          push_data
);

	localparam int ADDR_W = $clog2(MAX_WIDTH);

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;

	// position counters and geometry
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [COL_W-1:0] c_now;
	logic [ROW_W-1:0] r_now;
	logic             last_col_now;
	logic             last_row_now;
	logic             accept;
	logic [ADDR_W-1:0] rd_addr;
	logic [1:0]       inflight;

	// line stores
	smp_t upper_mem [MAX_WIDTH];
	smp_t middle_mem [MAX_WIDTH];

	// stage 1
	logic              s1_v;
	logic              fwd_s1;
	smp_t              sample_s1;
	smp_t              up_rd_s1;
	smp_t              mid_rd_s1;
	logic [COL_W-1:0]  c_s1;
	logic [ROW_W-1:0]  r_s1;
	logic              lc_s1;
	logic              lr_s1;
	logic [ADDR_W-1:0] wr_addr;
	smp_t              up_eff;
	smp_t              mid_eff;
	smp_t              prev_mid_q;
	smp_t              prev_smp_q;

	smp_t window_q [3][3];

	// stage 2
	logic             s2_v;
	logic [COL_W-1:0] c_s2;
	logic [ROW_W-1:0] r_s2;
	logic             lc_s2;
	logic             lr_s2;
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic             cand_a;
	logic             cand_b;
	logic             cand_c;
	logic             cand_d;

	function automatic logic is_peak(input smp_t cw [3][3], input logic [2:0] rok,
		input logic [2:0] cok, input int wr, input int wc);
		logic ok;
		int   i;
		int   j;
		ok = 1'b1;
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				if (!(i == wr && j == wc) && i >= wr - 1 && i <= wr + 1 &&
					j >= wc - 1 && j <= wc + 1 && rok[i] && cok[j] &&
					!(cw[wr][wc] > cw[i][j])) begin
					ok = 1'b0;
				end
			end
		end
		return ok;
	endfunction

	// clamp the frame size and saturate the position into it
	always_comb begin
		if (frame_width == '0) begin
			w_eff = COL_W'(1);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			w_eff = COL_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width;
		end
		h_eff        = (frame_height == '0) ? ROW_W'(1) : frame_height;
		c_now        = (col_q < w_eff) ? col_q : w_eff - COL_W'(1);
		r_now        = (row_q < h_eff) ? row_q : h_eff - ROW_W'(1);
		last_col_now = (c_now == w_eff - COL_W'(1));
		last_row_now = (r_now == h_eff - ROW_W'(1));
	end

	// credit check: every item in flight may still need a queue slot
	assign inflight        = {1'b0, s1_v} + {1'b0, s2_v};
	assign sample_ch.ready = (queue_free > QFREE_W'(inflight));
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign rd_addr         = ADDR_W'(c_now);
	assign wr_addr         = ADDR_W'(c_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_row_now && last_col_now) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col_now) begin
				col_q <= '0;
				row_q <= r_now + ROW_W'(1);
			end else begin
				col_q <= c_now + COL_W'(1);
				row_q <= r_now;
			end
		end
	end

	// line stores: read on intake, write back in s1
	always_ff @(posedge clk) begin
		if (s1_v) begin
			upper_mem[wr_addr] <= mid_eff;
		end
		if (accept) begin
			up_rd_s1 <= upper_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_v) begin
			middle_mem[wr_addr] <= sample_s1;
		end
		if (accept) begin
			mid_rd_s1 <= middle_mem[rd_addr];
		end
	end

	// same column written the cycle it is read (one-column frames)
	assign up_eff  = fwd_s1 ? prev_mid_q : up_rd_s1;
	assign mid_eff = fwd_s1 ? prev_smp_q : mid_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v   <= 1'b0;
			fwd_s1 <= 1'b0;
			s2_v   <= 1'b0;
		end else begin
			s1_v <= accept;
			s2_v <= s1_v;
			if (accept) begin
				fwd_s1 <= s1_v && (wr_addr == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= smp_t'(sample_ch.sample);
			c_s1      <= c_now;
			r_s1      <= r_now;
			lc_s1     <= last_col_now;
			lr_s1     <= last_row_now;
		end
		if (s1_v) begin
			prev_mid_q <= mid_eff;
			prev_smp_q <= sample_s1;
			c_s2       <= c_s1;
			r_s2       <= r_s1;
			lc_s2      <= lc_s1;
			lr_s2      <= lr_s1;
		end
	end

	// window shifts left, new column from the stores and the sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					window_q[i][j] <= '0;
				end
			end
		end else if (s1_v) begin
			for (int i = 0; i < 3; i++) begin
				window_q[i][0] <= window_q[i][1];
				window_q[i][1] <= window_q[i][2];
			end
			window_q[0][2] <= up_eff;
			window_q[1][2] <= mid_eff;
			window_q[2][2] <= sample_s1;
		end
	end

	// peak decision, candidates in decision order
	always_comb begin
		row_ok = {1'b1, r_s2 != '0, r_s2 > ROW_W'(1)};
		col_ok = {1'b1, c_s2 != '0, c_s2 > COL_W'(1)};
		cand_a = row_ok[1] && col_ok[1] && is_peak(window_q, row_ok, col_ok, 1, 1);
		cand_b = row_ok[1] && lc_s2 && is_peak(window_q, row_ok, col_ok, 1, 2);
		cand_c = lr_s2 && col_ok[1] && is_peak(window_q, row_ok, col_ok, 2, 1);
		cand_d = lr_s2 && lc_s2 && is_peak(window_q, row_ok, col_ok, 2, 2);

		push_data         = '0;
		push_data.verdict = lr_s2 && lc_s2;
		if (cand_a) begin
			push_data.peak_v      = 1'b1;
			push_data.peak_row    = r_s2;
			push_data.peak_column = c_s2;
		end else if (cand_b) begin
			push_data.peak_v      = 1'b1;
			push_data.peak_row    = r_s2;
			push_data.peak_column = c_s2 + COL_W'(1);
		end else if (cand_c) begin
			push_data.peak_v      = 1'b1;
			push_data.peak_row    = r_s2 + ROW_W'(1);
			push_data.peak_column = c_s2;
		end else if (cand_d) begin
			push_data.peak_v      = 1'b1;
			push_data.peak_row    = r_s2 + ROW_W'(1);
			push_data.peak_column = c_s2 + COL_W'(1);
		end
		push_v = s2_v && (push_data.peak_v || push_data.verdict);
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_v |-> queue_free != '0)
		else $error("decision pushed without queue room");

endmodule

// ===== rtl/lmpd_queue.sv =====
// ----------------------------------------------------------------------------
// lmpd_queue: decision queue between front end and report stage
// small register fifo with a free-slot count for the intake credit
// ----------------------------------------------------------------------------
module lmpd_queue import lmpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_v,
	input  decision_t          push_data,
	input  logic               pop,
	output logic               head_v,
	output decision_t          head,
	output logic [QFREE_W-1:0] queue_free
);

	decision_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFREE_W-1:0] count_q;

	assign head_v     = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign queue_free = QFREE_W'(QUEUE_DEPTH) - count_q;

	always_ff @(posedge clk) begin
		if (push_v) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_v) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push_v && !pop) begin
				count_q <= count_q + QFREE_W'(1);
			end else if (pop && !push_v) begin
				count_q <= count_q - QFREE_W'(1);
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QFREE_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/lmpd_back.sv =====
// ----------------------------------------------------------------------------
// lmpd_back: report stage
// numbers the peaks, tracks the target hit and drives the result register
// ----------------------------------------------------------------------------
module lmpd_back import lmpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_v,
	input  decision_t        head,
	input  logic [ROW_W-1:0] target_row,
	input  logic [COL_W-1:0] target_column,
	output logic             pop,
	lmpd_report_if.source    report_ch
);

	logic             out_v_q;
	logic             kind_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [NUM_W-1:0] num_q;
	logic             hit_out_q;
	logic             last_q;

	logic [NUM_W-1:0] tally_q;
	logic             hit_q;
	logic             peak_done_q;

	logic             load;
	logic             send_peak;
	logic [NUM_W-1:0] tally_next;
	logic             at_target;

	assign load       = head_v && (!out_v_q || report_ch.ready);
	assign send_peak  = head.peak_v && !peak_done_q;
	assign tally_next = (tally_q == TALLY_MAX) ? tally_q : tally_q + NUM_W'(1);
	assign at_target  = (head.peak_row == target_row) && (head.peak_column == target_column);
	assign pop        = load && !(send_peak && head.verdict);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			tally_q     <= '0;
			hit_q       <= 1'b0;
			peak_done_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
			end else if (report_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (load) begin
				if (send_peak) begin
					tally_q <= tally_next;
					if (at_target) begin
						hit_q <= 1'b1;
					end
					peak_done_q <= head.verdict;
				end else begin
					// verdict closes the frame
					tally_q     <= '0;
					hit_q       <= 1'b0;
					peak_done_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_peak) begin
				kind_q    <= KIND_PEAK;
				row_q     <= head.peak_row;
				col_q     <= head.peak_column;
				num_q     <= tally_next;
				hit_out_q <= 1'b0;
				last_q    <= !head.verdict;
			end else begin
				kind_q    <= KIND_VERDICT;
				row_q     <= '0;
				col_q     <= '0;
				num_q     <= tally_q;
				hit_out_q <= hit_q;
				last_q    <= 1'b1;
			end
		end
	end

	assign report_ch.valid       = out_v_q;
	assign report_ch.report_kind = kind_q;
	assign report_ch.peak_row    = row_q;
	assign report_ch.peak_column = col_q;
	assign report_ch.peak_number = num_q;
	assign report_ch.target_hit  = hit_out_q;
	assign report_ch.last        = last_q;

	a_tally_after_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(load && send_peak) |=> tally_q != '0)
		else $error("peak tally zero after a peak");

	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !send_peak) |=> (tally_q == '0) && !hit_q && !peak_done_q)
		else $error("frame counters not cleared after verdict");

endmodule

// ===== test/tb_local_maximum_3x3_peak_detector.sv =====
// ----------------------------------------------------------------------------
// tb_local_maximum_3x3_peak_detector: self-checking bench of the peak detector
// streams raster frames through the sample channel, predicts every peak report
// and frame verdict in a bit-exact software copy of the detector, and compares
// each result transaction field by field; both channels idle at random
// ----------------------------------------------------------------------------
module tb_local_maximum_3x3_peak_detector;
	import lmpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W    = DEF_MAX_WIDTH;
	localparam int SAMPLE_W = DEF_SAMPLE_BITS;

	// how the samples of one frame are made up
	typedef enum int {
		FILL_WILD,    // full 16-bit range
		FILL_NARROW,  // -2..2, lots of ties
		FILL_MIXED,   // extremes, zero and random
		FILL_GRID,    // isolated maxima on even rows and columns
		FILL_SCRIPT   // values taken from the script queue
	} fill_t;

	// one result transaction, as seen on the report channel
	typedef struct {
		report_kind_t     kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [NUM_W-1:0] num;
		logic             hit;
		logic             last;
	} report_t;

	// ------------------------------------------------------------------------
	// software copy of the detector plus the queue of reports it still owes
	// ------------------------------------------------------------------------
	class peak_ledger;
		int               upper_line [MAX_W];
		int               middle_line [MAX_W];
		int               win [3][3];
		int               col_pos;
		int               row_pos;
		logic [NUM_W-1:0] tally;
		logic             hit_mark;
		logic [COL_W-1:0] width_reg;
		logic [ROW_W-1:0] height_reg;
		logic [ROW_W-1:0] trow;
		logic [COL_W-1:0] tcol;
		report_t          expected [$];
		int               errors;

		function new();
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			trow       = RST_TARGET_ROW;
			tcol       = RST_TARGET_COLUMN;
			tally      = '0;
			hit_mark   = 1'b0;
		endfunction

		task flag(string msg);
			if (errors < 50)
				$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void set_config(cfg_index_t idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_FRAME_WIDTH:   width_reg  = v[COL_W-1:0];
				CFG_FRAME_HEIGHT:  height_reg = v[ROW_W-1:0];
				CFG_TARGET_ROW:    trow       = v[ROW_W-1:0];
				CFG_TARGET_COLUMN: tcol       = v[COL_W-1:0];
			endcase
		endfunction

		// window cell (wr,wc) holds frame position (r-2+wr, c-2+wc)
		function void decide_peak(int wr, int wc, int r, int c);
			int      centre;
			int      i;
			int      j;
			int      pr;
			int      pc;
			report_t rpt;
			centre = win[wr][wc];
			for (int di = -1; di <= 1; di++) begin
				for (int dj = -1; dj <= 1; dj++) begin
					i = wr + di;
					j = wc + dj;
					// own cell, not yet arrived, or outside the frame
					if ((di == 0 && dj == 0) || i > 2 || j > 2) continue;
					if (r - 2 + i < 0 || c - 2 + j < 0) continue;
					if (centre <= win[i][j]) return;
				end
			end
			pr = r - 2 + wr;
			pc = c - 2 + wc;
			if (tally < TALLY_MAX)
				tally++;
			if (pr + 1 == trow && pc + 1 == tcol)
				hit_mark = 1'b1;
			rpt = '{KIND_PEAK, ROW_W'(pr + 1), COL_W'(pc + 1), tally, 1'b0, 1'b0};
			expected.push_back(rpt);
		endfunction

		// one accepted sample transaction: advance the window, queue its reports
		function void take_sample(logic signed [SAMPLE_W-1:0] s);
			int      w;
			int      h;
			int      r;
			int      c;
			int      n_prev;
			bit      end_col;
			bit      end_row;
			report_t rpt;
			w = width_reg;
			if (w == 0) w = 1;
			if (w > MAX_W) w = MAX_W;
			h = height_reg;
			if (h == 0) h = 1;
			c = (col_pos < w) ? col_pos : w - 1;
			r = (row_pos < h) ? row_pos : h - 1;
			end_col = (c == w - 1);
			end_row = (r == h - 1);

			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2]      = upper_line[c];
			win[1][2]      = middle_line[c];
			win[2][2]      = s;
			upper_line[c]  = middle_line[c];
			middle_line[c] = s;

			n_prev = expected.size();
			if (r >= 1 && c >= 1) decide_peak(1, 1, r, c);
			if (r >= 1 && end_col) decide_peak(1, 2, r, c);
			if (end_row && c >= 1) decide_peak(2, 1, r, c);
			if (end_row && end_col) decide_peak(2, 2, r, c);

			if (end_row && end_col) begin
				rpt = '{KIND_VERDICT, '0, '0, tally, hit_mark, 1'b0};
				expected.push_back(rpt);
				col_pos  = 0;
				row_pos  = 0;
				tally    = '0;
				hit_mark = 1'b0;
			end else if (end_col) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
				row_pos = r;
			end

			// the final result of this sample carries last
			if (expected.size() > n_prev) begin
				rpt = expected.pop_back();
				rpt.last = 1'b1;
				expected.push_back(rpt);
			end
		endfunction

		task match_report(report_t got);
			report_t want;
			if (expected.size() == 0) begin
				flag("result transaction with nothing expected");
				return;
			end
			want = expected.pop_front();
			if (got.kind !== want.kind)
				flag($sformatf("report_kind got %0d want %0d", got.kind, want.kind));
			if (got.row !== want.row)
				flag($sformatf("peak_row got %0d want %0d", got.row, want.row));
			if (got.col !== want.col)
				flag($sformatf("peak_column got %0d want %0d", got.col, want.col));
			if (got.num !== want.num)
				flag($sformatf("peak_number got %0d want %0d", got.num, want.num));
			if (got.hit !== want.hit)
				flag($sformatf("target_hit got %0d want %0d", got.hit, want.hit));
			if (got.last !== want.last)
				flag($sformatf("last got %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	lmpd_sample_if smp ();
	lmpd_report_if rep ();

	peak_ledger ledger = new();

	bit steady;       // when set neither side idles
	int fed;          // accepted sample transactions since last cleared
	int script [$];   // sample values of a directed frame

	local_maximum_3x3_peak_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample_ch (smp),
		.report_ch (rep)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// one register write; the caller lowers cfg_we after the last one
	task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		ledger.set_config(idx, v);
	endtask

	// configure, stream one whole frame, then wait for its verdict and let
	// the pipeline settle before anything else touches the registers
	task automatic run_frame(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw,
	                         logic [CFG_W-1:0] t_row, logic [CFG_W-1:0] t_col,
	                         fill_t fill);
		int                          w;
		int                          h;
		int                          r;
		int                          c;
		int                          low;
		logic signed [SAMPLE_W-1:0]  v;
		write_reg(CFG_FRAME_WIDTH, w_raw);
		write_reg(CFG_FRAME_HEIGHT, h_raw);
		write_reg(CFG_TARGET_ROW, t_row);
		write_reg(CFG_TARGET_COLUMN, t_col);
		cfg_we <= 1'b0;

		// zero and oversize widths fold into the legal range
		w = w_raw[COL_W-1:0];
		if (w == 0) w = 1;
		if (w > MAX_W) w = MAX_W;
		h = h_raw[ROW_W-1:0];
		if (h == 0) h = 1;

		for (int i = 0; i < w * h; i++) begin
			r = i / w;
			c = i % w;
			case (fill)
				FILL_WILD:   v = $urandom;
				FILL_NARROW: v = int'($urandom_range(0, 4)) - 2;
				FILL_MIXED: begin
					case ($urandom_range(0, 3))
						0:       v = 16'sh7fff;
						1:       v = 16'sh8000;
						2:       v = '0;
						default: v = $urandom;
					endcase
				end
				FILL_GRID: begin
					if (r % 2 == 0 && c % 2 == 0) begin
						v = $urandom_range(1, 32767);
					end else begin
						low = $urandom_range(0, 32768);
						v = -low;
					end
				end
				default: v = script[i];
			endcase

			// random sender gaps
			while (!steady && $urandom_range(0, 99) < 8) begin
				smp.valid <= 1'b0;
				@(posedge clk);
			end
			smp.valid  <= 1'b1;
			smp.sample <= v;
			do @(posedge clk); while (!smp.ready);
			ledger.take_sample(v);
			fed++;
		end
		smp.valid <= 1'b0;

		while (ledger.expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// result side: check every accepted transaction, stall at random
	initial begin
		report_t got;
		rep.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rep.valid === 1'b1 && rep.ready === 1'b1) begin
				got.kind = report_kind_t'(rep.report_kind);
				got.row  = rep.peak_row;
				got.col  = rep.peak_column;
				got.num  = rep.peak_number;
				got.hit  = rep.target_hit;
				got.last = rep.last;
				ledger.match_report(got);
			end
			rep.ready <= !(!steady && $urandom_range(0, 99) < 8);
		end
	end

	// stimulus
	initial begin
		int          w;
		int          h;
		logic [15:0] w_raw;
		fill_t       fill;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_FRAME_WIDTH;
		cfg_wdata  = '0;
		smp.valid  = 1'b0;
		smp.sample = '0;
		steady     = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single sample frame: lone sample is a peak, hit on the target
		script = '{32767};
		run_frame(16'd1, 16'd1, 16'd1, 16'd1, FILL_SCRIPT);
		// zero width and zero height both count as one
		script = '{-32768};
		run_frame(16'd0, 16'd0, 16'd1, 16'd1, FILL_SCRIPT);
		// centre peak of a 3x3 frame, equal neighbors elsewhere
		script = '{0, 0, 0, 0, 5, 0, 0, 0, 0};
		run_frame(16'd3, 16'd3, 16'd2, 16'd2, FILL_SCRIPT);
		// plateau: ties are never peaks, verdict total zero
		script = '{7, 7, 7, 7, 7, 7};
		run_frame(16'd3, 16'd2, 16'd1, 16'd1, FILL_SCRIPT);
		// sample extremes in a 2x2 frame
		script = '{-32768, 32767, 32766, -32768};
		run_frame(16'd2, 16'd2, 16'd1, 16'd2, FILL_SCRIPT);

		// random small frames, upper register bits sometimes set
		fed = 0;
		while (fed < 500) begin
			// no idling on either side through the middle of the run
			steady = (fed >= 200 && fed < 350);
			case ($urandom_range(0, 19)) inside
				[0:13]:  w = $urandom_range(1, 8);
				[14:17]: w = $urandom_range(9, 40);
				default: w = 0;
			endcase
			h = $urandom_range(0, 8);
			w_raw = {5'($urandom), 11'(w)};
			fill = fill_t'($urandom_range(FILL_WILD, FILL_GRID));
			run_frame(w_raw, 16'(h),
			          16'($urandom_range(1, (h == 0) ? 1 : h)),
			          16'($urandom_range(1, (w == 0) ? 1 : w)), fill);
		end
		steady = 1'b0;

		if (ledger.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lmpd_pkg.sv
rtl/lmpd_sample_if.sv
rtl/lmpd_report_if.sv
rtl/lmpd_front.sv
rtl/lmpd_queue.sv
rtl/lmpd_back.sv
rtl/local_maximum_3x3_peak_detector.sv
test/tb_local_maximum_3x3_peak_detector.sv
